### rtl/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// shared types and constants of the uv sphere mesh generator
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int DEF_MAX_SLICES = 256;
  localparam int DEF_MAX_STACKS = 256;

  // restoring divider: dividend bits (one per stage) and divisor bits
  localparam int DIV_W  = 25;
  localparam int DIVR_W = 9;

  // cordic: two iterations per stage, then a quadrant mapping stage
  localparam int CORDIC_STAGES = 8;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 1;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef logic [17:0] atan_t;
  localparam atan_t ATAN_TAB [16] = '{
    18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213, 18'd2607, 18'd1304,
    18'd652,    18'd326,   18'd163,   18'd81,    18'd41,    18'd20,   18'd10,   18'd5
  };

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_QUAD   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SLICE_COUNT = 3'd0,
    REG_STACK_COUNT = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_SWEEP       = 3'd3,
    REG_TEX_U       = 3'd4,
    REG_TEX_V       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic               neg_u;
    logic               neg_v;
    logic [16:0]        base;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } side_t;

endpackage

### rtl/uvs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_in_if
// request channel: command, stack and slice
// ----------------------------------------------------------------------------
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [8:0] stack_index;
  logic [7:0] slice_index;

  modport source (output valid, command, stack_index, slice_index, input ready);
  modport sink   (input valid, command, stack_index, slice_index, output ready);
endinterface

### rtl/uvs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_out_if
// result channel: vertex attributes or triangle corners
// ----------------------------------------------------------------------------
interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic [16:0]        corner_a;
  logic [16:0]        corner_b;
  logic [16:0]        corner_c;
  logic               last_of_run;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  corner_a, corner_b, corner_c, last_of_run, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  corner_a, corner_b, corner_c, last_of_run, output ready);
endinterface

### rtl/uvs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface uvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/uv_sphere_mesh_generator_top.sv
`timescale 1ns / 1ps
// throughput: one vertex request per cycle while the output is not held, fewer with quad requests
// rate set by the single output register, which holds a quad for its two triangles
// the whole pipeline advances together and stalls as one when the output is held
// reset: synchronous active low, registers back to defaults, pipeline emptied
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_top
// latitude-longitude sphere vertices and quad triangles from requests
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_top import uvs_pkg::*; #(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int MAX_STACKS = DEF_MAX_STACKS
) (
  input  logic     clk,
  input  logic     rst_n,
  uvs_in_if.sink   in_ch,
  uvs_out_if.source out_ch,
  uvs_cfg_if.sink  cfg_ch
);

  localparam int DIV_LAT = DIV_W;

  // configuration
  logic [8:0]         slice_count_r, stack_count_r;
  logic [15:0]        radius_r, sweep_r;
  logic signed [15:0] tex_scale_u_r, tex_scale_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r <= 9'd16;
      stack_count_r <= 9'd16;
      radius_r      <= 16'd256;
      sweep_r       <= 16'd32768;
      tex_scale_u_r <= 16'sd256;
      tex_scale_v_r <= 16'sd256;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_SLICE_COUNT: slice_count_r <= cfg_ch.data[8:0];
        REG_STACK_COUNT: stack_count_r <= cfg_ch.data[8:0];
        REG_RADIUS:      radius_r      <= cfg_ch.data;
        REG_SWEEP:       sweep_r       <= cfg_ch.data;
        REG_TEX_U:       tex_scale_u_r <= $signed(cfg_ch.data);
        REG_TEX_V:       tex_scale_v_r <= $signed(cfg_ch.data);
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // effective counts
  logic [8:0] s_cnt, t_cnt, s_m1;

  always_comb begin
    if (slice_count_r < 9'd2) begin
      s_cnt = 9'd2;
    end else if (int'(slice_count_r) > MAX_SLICES) begin
      s_cnt = 9'(MAX_SLICES);
    end else begin
      s_cnt = slice_count_r;
    end
    if (stack_count_r < 9'd1) begin
      t_cnt = 9'd1;
    end else if (int'(stack_count_r) > MAX_STACKS) begin
      t_cnt = 9'(MAX_STACKS);
    end else begin
      t_cnt = stack_count_r;
    end
    s_m1 = s_cnt - 9'd1;
  end

  logic adv;

  // request stage
  logic        in_ok;
  logic [15:0] tsu_abs, tsv_abs;
  logic [18:0] base_full;
  side_t       a_side_r, a_side_nxt;
  logic [DIV_W-1:0] a_tn_r, a_pn_r, a_un_r, a_vn_r;

  always_comb begin
    if (cmd_t'(in_ch.command) == CMD_VERTEX) begin
      in_ok = (in_ch.stack_index <= t_cnt) && ({1'b0, in_ch.slice_index} < s_cnt);
    end else begin
      in_ok = (in_ch.stack_index < t_cnt) && ({1'b0, in_ch.slice_index} < s_m1);
    end
    tsu_abs   = tex_scale_u_r[15] ? 16'(-tex_scale_u_r) : 16'(tex_scale_u_r);
    tsv_abs   = tex_scale_v_r[15] ? 16'(-tex_scale_v_r) : 16'(tex_scale_v_r);
    base_full = 19'(in_ch.stack_index) * 19'(s_cnt) + 19'(in_ch.slice_index);
    a_side_nxt.valid = in_ch.valid && in_ok;
    a_side_nxt.cmd   = cmd_t'(in_ch.command);
    a_side_nxt.neg_u = tex_scale_u_r[15];
    a_side_nxt.neg_v = tex_scale_v_r[15];
    a_side_nxt.base  = base_full[16:0];
    a_side_nxt.tex_u = '0;
    a_side_nxt.tex_v = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r.valid <= 1'b0;
    end else if (adv) begin
      a_side_r <= a_side_nxt;
      a_tn_r   <= DIV_W'(in_ch.stack_index) * DIV_W'(sweep_r);
      a_pn_r   <= DIV_W'({in_ch.slice_index, 16'h0000});
      a_un_r   <= DIV_W'(tsu_abs) * DIV_W'(in_ch.slice_index);
      a_vn_r   <= DIV_W'(tsv_abs) * DIV_W'(in_ch.stack_index);
    end
  end

  assign in_ch.ready = adv;

  // dividers
  logic [DIV_W-1:0] q_t, q_p, q_u, q_v;

  uvs_div #(.DW(DIV_W), .VW(DIVR_W)) u_div_theta (
    .clk(clk), .en(adv), .dividend(a_tn_r), .divisor(t_cnt), .quotient(q_t));
  uvs_div #(.DW(DIV_W), .VW(DIVR_W)) u_div_phi (
    .clk(clk), .en(adv), .dividend(a_pn_r), .divisor(s_m1), .quotient(q_p));
  uvs_div #(.DW(DIV_W), .VW(DIVR_W)) u_div_texu (
    .clk(clk), .en(adv), .dividend(a_un_r), .divisor(s_m1), .quotient(q_u));
  uvs_div #(.DW(DIV_W), .VW(DIVR_W)) u_div_texv (
    .clk(clk), .en(adv), .dividend(a_vn_r), .divisor(t_cnt), .quotient(q_v));

  side_t sd1_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sd1_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      sd1_r[0] <= a_side_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd1_r[k] <= sd1_r[k-1];
      end
    end
  end

  // texture saturation
  function automatic logic signed [15:0] sat_tex(logic [DIV_W-1:0] q, logic neg);
    logic [DIV_W-1:0] nq;
    nq = -q;
    if (!neg) begin
      return (q > DIV_W'(32767)) ? 16'sh7fff : $signed(q[15:0]);
    end
    return (q > DIV_W'(32768)) ? 16'sh8000 : $signed(nq[15:0]);
  endfunction

  side_t d_side;

  always_comb begin
    d_side       = sd1_r[DIV_LAT-1];
    d_side.tex_u = sat_tex(q_u, sd1_r[DIV_LAT-1].neg_u);
    d_side.tex_v = sat_tex(q_v, sd1_r[DIV_LAT-1].neg_v);
  end

  // sine and cosine
  logic signed [31:0] ct, st, cp, sp;

  uvs_cordic u_cordic_theta (.clk(clk), .en(adv), .angle(q_t[15:0]), .cos_o(ct), .sin_o(st));
  uvs_cordic u_cordic_phi   (.clk(clk), .en(adv), .angle(q_p[15:0]), .cos_o(cp), .sin_o(sp));

  side_t sd2_r [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_LAT; k++) begin
        sd2_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      sd2_r[0] <= d_side;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        sd2_r[k] <= sd2_r[k-1];
      end
    end
  end

  function automatic logic signed [63:0] rnd(logic signed [63:0] v, int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (!v[63]) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  // unit vector and position
  side_t              m1_side_r, m2_side_r, m3_side_r;
  logic signed [63:0] p0_r, p2_r;
  logic signed [31:0] m1_u1_r;
  logic signed [31:0] m2_u0_r, m2_u1_r, m2_u2_r;
  logic signed [31:0] m3_u0_r, m3_u1_r, m3_u2_r;
  logic signed [48:0] m3_q0_r, m3_q1_r, m3_q2_r;
  logic signed [63:0] r0, r2;
  logic signed [16:0] rad_s;

  always_comb begin
    r0    = rnd(p0_r, 30);
    r2    = rnd(p2_r, 30);
    rad_s = $signed({1'b0, radius_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_side_r.valid <= 1'b0;
      m2_side_r.valid <= 1'b0;
      m3_side_r.valid <= 1'b0;
    end else if (adv) begin
      m1_side_r <= sd2_r[CORDIC_LAT-1];
      p0_r      <= 64'(cp * st);
      p2_r      <= 64'(sp * st);
      m1_u1_r   <= ct;
      m2_side_r <= m1_side_r;
      m2_u0_r   <= r0[31:0];
      m2_u1_r   <= m1_u1_r;
      m2_u2_r   <= r2[31:0];
      m3_side_r <= m2_side_r;
      m3_u0_r   <= m2_u0_r;
      m3_u1_r   <= m2_u1_r;
      m3_u2_r   <= m2_u2_r;
      m3_q0_r   <= 49'(rad_s * m2_u0_r);
      m3_q1_r   <= 49'(rad_s * m2_u1_r);
      m3_q2_r   <= 49'(rad_s * m2_u2_r);
    end
  end

  function automatic logic signed [16:0] sat_pos(logic signed [48:0] q);
    logic signed [63:0] v;
    v = rnd(64'(q), 30);
    if (v > 64'sd65535) begin
      return 17'sd65535;
    end else if (v < -64'sd65535) begin
      return -17'sd65535;
    end
    return v[16:0];
  endfunction

  function automatic logic signed [15:0] sat_norm(logic signed [31:0] u);
    logic signed [63:0] v;
    v = rnd(64'(u), 15);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic signed [16:0] f_px, f_py, f_pz;
  logic signed [15:0] f_nx, f_ny, f_nz;

  always_comb begin
    if (radius_r == 16'd0) begin
      f_px = '0; f_py = '0; f_pz = '0;
      f_nx = '0; f_ny = '0; f_nz = '0;
    end else begin
      f_px = sat_pos(m3_q0_r);
      f_py = sat_pos(m3_q1_r);
      f_pz = sat_pos(m3_q2_r);
      f_nx = sat_norm(m3_u0_r);
      f_ny = sat_norm(m3_u1_r);
      f_nz = sat_norm(m3_u2_r);
    end
  end

  // output register, a quad is held for its two triangles
  logic               o_valid_r, o_phase_r;
  cmd_t               o_cmd_r;
  logic signed [16:0] o_px_r, o_py_r, o_pz_r;
  logic signed [15:0] o_nx_r, o_ny_r, o_nz_r, o_tu_r, o_tv_r;
  logic [16:0]        o_base_r;
  logic               out_xfer;

  assign out_xfer = o_valid_r && out_ch.ready;
  assign adv      = !o_valid_r || (out_ch.ready && (o_cmd_r == CMD_VERTEX || o_phase_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      o_phase_r <= 1'b0;
      o_cmd_r   <= CMD_VERTEX;
    end else if (adv) begin
      o_valid_r <= m3_side_r.valid;
      o_phase_r <= 1'b0;
      o_cmd_r   <= m3_side_r.cmd;
      o_px_r    <= f_px;
      o_py_r    <= f_py;
      o_pz_r    <= f_pz;
      o_nx_r    <= f_nx;
      o_ny_r    <= f_ny;
      o_nz_r    <= f_nz;
      o_tu_r    <= m3_side_r.tex_u;
      o_tv_r    <= m3_side_r.tex_v;
      o_base_r  <= m3_side_r.base;
    end else if (out_xfer) begin
      o_phase_r <= 1'b1;
    end
  end

  logic [16:0] b_s, b_1, b_s1;

  always_comb begin
    b_s  = o_base_r + 17'(s_cnt);
    b_1  = o_base_r + 17'd1;
    b_s1 = o_base_r + 17'(s_cnt) + 17'd1;
    out_ch.valid = o_valid_r;
    if (o_cmd_r == CMD_VERTEX) begin
      out_ch.pos_x       = o_px_r;
      out_ch.pos_y       = o_py_r;
      out_ch.pos_z       = o_pz_r;
      out_ch.norm_x      = o_nx_r;
      out_ch.norm_y      = o_ny_r;
      out_ch.norm_z      = o_nz_r;
      out_ch.tex_u       = o_tu_r;
      out_ch.tex_v       = o_tv_r;
      out_ch.corner_a    = o_base_r;
      out_ch.corner_b    = '0;
      out_ch.corner_c    = '0;
      out_ch.last_of_run = 1'b1;
    end else begin
      out_ch.pos_x       = '0;
      out_ch.pos_y       = '0;
      out_ch.pos_z       = '0;
      out_ch.norm_x      = '0;
      out_ch.norm_y      = '0;
      out_ch.norm_z      = '0;
      out_ch.tex_u       = '0;
      out_ch.tex_v       = '0;
      out_ch.corner_a    = b_s;
      out_ch.corner_b    = o_phase_r ? b_s1 : b_1;
      out_ch.corner_c    = o_phase_r ? b_1 : o_base_r;
      out_ch.last_of_run = o_phase_r;
    end
  end

`ifndef SYNTHESIS
  a_phase_quad: assert property (@(posedge clk) disable iff (!rst_n)
    o_phase_r |-> (o_valid_r && o_cmd_r == CMD_QUAD))
    else $error("second triangle phase without a quad");

  a_vertex_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_cmd_r == CMD_VERTEX) |->
      (out_ch.last_of_run && out_ch.corner_b == 17'd0 && out_ch.corner_c == 17'd0))
    else $error("vertex result with triangle fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(m3_side_r))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

### rtl/uvs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = DIVR_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient
);

  logic [VW-1:0] rem_r   [DW];
  logic [DW-1:0] nq_r    [DW];
  logic [VW-1:0] rem_nxt [DW];
  logic [DW-1:0] nq_nxt  [DW];

  function automatic logic [VW+DW-1:0] dstep(logic [VW-1:0] rem, logic [DW-1:0] nq,
                                             logic [VW-1:0] d);
    logic [VW:0] trial;
    logic        ge;
    trial = {rem, nq[DW-1]};
    ge    = (trial >= {1'b0, d});
    if (ge) begin
      trial = trial - {1'b0, d};
    end
    return {trial[VW-1:0], nq[DW-2:0], ge};
  endfunction

  always_comb begin
    {rem_nxt[0], nq_nxt[0]} = dstep({VW{1'b0}}, dividend, divisor);
    for (int k = 1; k < DW; k++) begin
      {rem_nxt[k], nq_nxt[k]} = dstep(rem_r[k-1], nq_r[k-1], divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DW; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
      end
    end
  end

  assign quotient = nq_r[DW-1];

endmodule

### rtl/uvs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cordic
// pipelined rotation cordic, cos and sin of an angle in turns/65536, q2.30
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [20:0] z;
    logic [1:0]         quad;
  } cst_t;

  cst_t               st_r   [CORDIC_STAGES];
  cst_t               st_nxt [CORDIC_STAGES];
  cst_t               init;
  logic signed [31:0] cos_r, sin_r;
  logic signed [31:0] cos_nxt, sin_nxt;

  function automatic cst_t rot(cst_t s, int i);
    cst_t               r;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [20:0] at;
    r  = s;
    dx = s.y >>> i;
    dy = s.x >>> i;
    at = $signed({3'b000, ATAN_TAB[i]});
    if (!s.z[20]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - at;
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + at;
    end
    return r;
  endfunction

  always_comb begin
    init.x    = CORDIC_GAIN;
    init.y    = '0;
    init.z    = $signed({3'b000, angle[13:0], 4'b0000});
    init.quad = angle[15:14];
    st_nxt[0] = rot(rot(init, 0), 1);
    for (int k = 1; k < CORDIC_STAGES; k++) begin
      st_nxt[k] = rot(rot(st_r[k-1], 2 * k), 2 * k + 1);
    end
  end

  // quadrant mapping
  always_comb begin
    case (st_r[CORDIC_STAGES-1].quad)
      2'd0: begin
        cos_nxt = st_r[CORDIC_STAGES-1].x;
        sin_nxt = st_r[CORDIC_STAGES-1].y;
      end
      2'd1: begin
        cos_nxt = -st_r[CORDIC_STAGES-1].y;
        sin_nxt = st_r[CORDIC_STAGES-1].x;
      end
      2'd2: begin
        cos_nxt = -st_r[CORDIC_STAGES-1].x;
        sin_nxt = -st_r[CORDIC_STAGES-1].y;
      end
      default: begin
        cos_nxt = st_r[CORDIC_STAGES-1].y;
        sin_nxt = -st_r[CORDIC_STAGES-1].x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
